// File: sv/hsort_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hsort_pkg
// Shared types and constants for the heap sorter: item payloads, controller
// states, and the command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package hsort_pkg;

    localparam int ITEM_W = 32;   // payload width of value and sorted_value
    localparam int EXT_W  = 64;   // widest element the store can hold

    typedef struct packed {
        logic signed [ITEM_W-1:0] value;
        logic                     is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [ITEM_W-1:0] sorted_value;
        logic                     is_final;
    } t_out_item;

    typedef enum logic [3:0] {
        S_COLLECT,
        S_BUILD_CHK,
        S_BUILD_LD,
        S_BUILD_SIFT,
        S_SORT_CHK,
        S_SORT_LD,
        S_SORT_SIFT,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_HOLD
    } t_state;

    typedef struct packed {
        logic take_in;    // input ready; store item at fill count
        logic build_rd;   // read next heapify root
        logic sift_load;  // load sift value, fetch its children
        logic sift_step;  // one level of sift-down
        logic sort_init;  // heap end <= set size
        logic sort_rd;    // read root and heap end
        logic sort_load;  // move root to heap end, sift old last from root
        logic out_init;   // output index <= 0
        logic out_rd;     // read output entry
        logic out_load;   // load output register
        logic out_valid;  // output register holds an item
        logic out_next;   // advance output index
    } t_cmd;

    typedef struct packed {
        logic in_final;   // accepted item closes the set
        logic i_zero;     // loop index is zero
        logic i_le1;      // loop index is zero or one
        logic sift_done;  // sifted value has come to rest
        logic out_taken;  // output item taken this cycle
        logic out_last;   // output item is the last of the set
    } t_status;

endpackage
`default_nettype wire

// File: sv/hsort_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hsort_if
// Valid/ready channel carrying one item per handshake.
// ---------------------------------------------------------------------------
interface hsort_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/heap_sorter.sv
`default_nettype none
// Heap sorter: collects a set of up to DEPTH values, one per cycle while collecting.
// After the final item: heapify n/2 sifts, then n-1 extractions. Each sift reads its
// root, loads the moving value, then sifts one heap level per step, reading both
// children together from the two-port store. Each result is read, loaded and held.
// No input is taken while a set is sorted or emitted. Synchronous active-low reset
// empties the store count and returns to collecting; store contents are not cleared.
// ---------------------------------------------------------------------------
// heap_sorter
// Top level: controller plus datapath over one element store.
// ---------------------------------------------------------------------------
module heap_sorter #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hsort_if.sink     i_sort_in,
    hsort_if.source   o_sort_out
);
    import hsort_pkg::*;

    t_cmd    cmd;
    t_status status;

    hsort_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    hsort_dp #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_sort_in  (i_sort_in),
        .o_sort_out (o_sort_out)
    );
endmodule
`default_nettype wire

// File: sv/hsort_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hsort_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module hsort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

// File: sv/hsort_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hsort_ctrl
// Sequencer: collect, heapify, extract, emit.
// ---------------------------------------------------------------------------
module hsort_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire hsort_pkg::t_status i_status,
    output hsort_pkg::t_cmd        o_cmd
);
    import hsort_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_COLLECT: begin
                o_cmd.take_in = 1'b1;
                if (i_status.in_final) begin
                    n_state = S_BUILD_CHK;
                end
            end
            S_BUILD_CHK: begin
                if (i_status.i_zero) begin
                    o_cmd.sort_init = 1'b1;
                    n_state = S_SORT_CHK;
                end else begin
                    o_cmd.build_rd = 1'b1;
                    n_state = S_BUILD_LD;
                end
            end
            S_BUILD_LD: begin
                o_cmd.sift_load = 1'b1;
                n_state = S_BUILD_SIFT;
            end
            S_BUILD_SIFT: begin
                o_cmd.sift_step = 1'b1;
                if (i_status.sift_done) begin
                    n_state = S_BUILD_CHK;
                end
            end
            S_SORT_CHK: begin
                if (i_status.i_le1) begin
                    o_cmd.out_init = 1'b1;
                    n_state = S_OUT_RD;
                end else begin
                    o_cmd.sort_rd = 1'b1;
                    n_state = S_SORT_LD;
                end
            end
            S_SORT_LD: begin
                o_cmd.sort_load = 1'b1;
                n_state = S_SORT_SIFT;
            end
            S_SORT_SIFT: begin
                o_cmd.sift_step = 1'b1;
                if (i_status.sift_done) begin
                    n_state = S_SORT_CHK;
                end
            end
            S_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                o_cmd.out_load = 1'b1;
                n_state = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                o_cmd.out_valid = 1'b1;
                if (i_status.out_taken) begin
                    if (i_status.out_last) begin
                        n_state = S_COLLECT;
                    end else begin
                        o_cmd.out_next = 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: sv/hsort_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hsort_dp
// Datapath: element store, loop indexes, sift-down compare and output register.
// Sift-down keeps the moving value in a register and writes children upward,
// the value itself once at rest; each level reads both children together.
// ---------------------------------------------------------------------------
module hsort_dp #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hsort_pkg::t_cmd    i_cmd,
    output hsort_pkg::t_status      o_status,
    hsort_if.sink                   i_sort_in,
    hsort_if.source                 o_sort_out
);
    import hsort_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = AW + 2;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_i;
    logic [CW-1:0]    r_size;
    logic [CW-1:0]    r_k;
    logic [AW-1:0]    r_root;
    logic [WIDTH-1:0] r_v;
    t_out_item        r_out;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [WIDTH-1:0] wdata;
    logic [AW-1:0]    raddr_a;
    logic [AW-1:0]    raddr_b;
    logic [WIDTH-1:0] rd_a;
    logic [WIDTH-1:0] rd_b;

    logic             acc;
    logic             in_final;
    logic [CW-1:0]    n_in;
    logic [CW-1:0]    i_dec;
    logic [EXT_W-1:0] in_ext;
    logic [WIDTH-1:0] elem;
    logic [EXT_W-1:0] out_ext;

    logic [XW-1:0]    l_full;
    logic [XW-1:0]    r_full;
    logic [XW-1:0]    size_x;
    logic             l_ok;
    logic             r_ok;
    logic             gt_lv;
    logic             gt_rv;
    logic             gt_rl;
    logic             take_l;
    logic             take_r;
    logic             sift_done;
    logic [AW-1:0]    top_idx;
    logic [WIDTH-1:0] top_val;
    logic [AW-1:0]    p_next;
    logic [XW-1:0]    kid_l;
    logic [XW-1:0]    kid_r;

    hsort_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign acc      = i_cmd.take_in & i_sort_in.valid;
    assign in_final = i_sort_in.data.is_last | (r_count == CW'(DEPTH - 1));
    assign n_in     = r_count + CW'(1);
    assign i_dec    = r_i - CW'(1);
    assign in_ext   = EXT_W'($unsigned(i_sort_in.data.value));
    assign elem     = in_ext[WIDTH-1:0];
    assign out_ext  = EXT_W'(rd_a);

    // children of the current root; r_full may exceed the store, gated by r_ok
    assign l_full = {1'b0, r_root, 1'b1};
    assign r_full = l_full + XW'(1);
    assign size_x = XW'(r_size);
    assign l_ok   = l_full < size_x;
    assign r_ok   = r_full < size_x;
    assign gt_lv  = $signed(rd_a) > $signed(r_v);
    assign gt_rv  = $signed(rd_b) > $signed(r_v);
    assign gt_rl  = $signed(rd_b) > $signed(rd_a);
    assign take_l = l_ok & gt_lv;
    assign take_r = r_ok & gt_rv & (~take_l | gt_rl);
    assign sift_done = ~take_l & ~take_r;
    assign top_idx = take_r ? r_full[AW-1:0] : l_full[AW-1:0];
    assign top_val = take_r ? rd_b : rd_a;

    // prefetch children of the root that the next sift step will see
    assign p_next = i_cmd.sift_step ? top_idx : r_root;
    assign kid_l  = {1'b0, p_next, 1'b1};
    assign kid_r  = kid_l + XW'(1);

    always_comb begin
        we      = 1'b0;
        waddr   = r_count[AW-1:0];
        wdata   = elem;
        raddr_a = kid_l[AW-1:0];
        raddr_b = kid_r[AW-1:0];
        if (acc) begin
            we = 1'b1;
        end else if (i_cmd.sort_load) begin
            we    = 1'b1;
            waddr = r_size[AW-1:0];
            wdata = rd_a;
        end else if (i_cmd.sift_step) begin
            we    = 1'b1;
            waddr = r_root;
            wdata = sift_done ? r_v : top_val;
        end
        if (i_cmd.build_rd) begin
            raddr_a = i_dec[AW-1:0];
        end else if (i_cmd.sort_rd) begin
            raddr_a = '0;
            raddr_b = i_dec[AW-1:0];
        end else if (i_cmd.out_rd) begin
            raddr_a = r_k[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_n     <= '0;
            r_i     <= '0;
            r_size  <= '0;
            r_k     <= '0;
            r_root  <= '0;
        end else begin
            if (acc) begin
                if (in_final) begin
                    r_count <= '0;
                    r_n     <= n_in;
                    r_i     <= n_in >> 1;
                end else begin
                    r_count <= n_in;
                end
            end
            if (i_cmd.build_rd) begin
                r_root <= i_dec[AW-1:0];
                r_size <= r_n;
                r_i    <= i_dec;
            end
            if (i_cmd.sort_init) begin
                r_i <= r_n;
            end
            if (i_cmd.sort_rd) begin
                r_root <= '0;
                r_size <= i_dec;
                r_i    <= i_dec;
            end
            if (i_cmd.sift_step && !sift_done) begin
                r_root <= top_idx;
            end
            if (i_cmd.out_init) begin
                r_k <= '0;
            end
            if (i_cmd.out_next) begin
                r_k <= r_k + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sift_load) begin
            r_v <= rd_a;
        end else if (i_cmd.sort_load) begin
            r_v <= rd_b;
        end
        if (i_cmd.out_load) begin
            r_out.sorted_value <= out_ext[ITEM_W-1:0];
            r_out.is_final     <= (r_k + CW'(1)) == r_n;
        end
    end

    assign i_sort_in.ready  = i_cmd.take_in;
    assign o_sort_out.valid = i_cmd.out_valid;
    assign o_sort_out.data  = r_out;

    assign o_status.in_final  = acc & in_final;
    assign o_status.i_zero    = r_i == '0;
    assign o_status.i_le1     = r_i <= CW'(1);
    assign o_status.sift_done = sift_done;
    assign o_status.out_taken = i_cmd.out_valid & o_sort_out.ready;
    assign o_status.out_last  = r_out.is_final;
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: heap sorter testbench
// Drives sets of signed values into the sorter with random gaps on both
// channels. A scoreboard heap-sorts each set as it closes, either on the last
// flag or when the store fills, and checks every sorted item in order.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hsort_pkg::*;

    localparam int SET_DEPTH    = 64;
    localparam int RANDOM_ITEMS = 390;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 60;
    localparam int MAX_SHOWN    = 10;

    typedef logic signed [ITEM_W-1:0] t_elem;
    typedef t_elem t_elem_q[$];

    localparam t_elem VAL_MAX = 32'sh7FFF_FFFF;
    localparam t_elem VAL_MIN = 32'sh8000_0000;

    // Collects the elements of the open set; on close, heap-sorts them and
    // queues the sorted items the block must emit.
    class sort_checker;
        localparam int CAP = 64;
        t_elem     set_store[CAP];
        int        set_fill;
        t_out_item sorted_due[$];
        int        errors;

        function new();
            set_fill = 0;
            errors   = 0;
        endfunction

        function int pending();
            return sorted_due.size();
        endfunction

        function void sift_down(int root, int size);
            int    top;
            int    lc;
            int    rc;
            t_elem tmp;
            while (1) begin
                top = root;
                lc  = 2 * root + 1;
                rc  = 2 * root + 2;
                if (lc < size && set_store[lc] > set_store[top]) top = lc;
                if (rc < size && set_store[rc] > set_store[top]) top = rc;
                if (top == root) break;
                tmp             = set_store[root];
                set_store[root] = set_store[top];
                set_store[top]  = tmp;
                root            = top;
            end
        endfunction

        function void heap_sort_set(int n);
            t_elem tmp;
            for (int i = n / 2; i > 0; i--) sift_down(i - 1, n);
            for (int i = n; i > 1; i--) begin
                tmp              = set_store[0];
                set_store[0]     = set_store[i - 1];
                set_store[i - 1] = tmp;
                sift_down(0, i - 1);
            end
        endfunction

        function void take_element(t_in_item it);
            t_out_item res;
            set_store[set_fill] = it.value;
            set_fill++;
            if (it.is_last || set_fill == CAP) begin
                heap_sort_set(set_fill);
                for (int k = 0; k < set_fill; k++) begin
                    res.sorted_value = set_store[k];
                    res.is_final     = (k == set_fill - 1);
                    sorted_due.push_back(res);
                end
                set_fill = 0;
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_SHOWN) $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void check_sorted(t_out_item got);
            t_out_item want;
            if (sorted_due.size() == 0) begin
                report($sformatf("unexpected item value=%0d final=%0b",
                                 got.sorted_value, got.is_final));
                return;
            end
            want = sorted_due.pop_front();
            if (got.sorted_value !== want.sorted_value)
                report($sformatf("sorted_value expected %0d got %0d",
                                 want.sorted_value, got.sorted_value));
            if (got.is_final !== want.is_final)
                report($sformatf("is_final expected %0b got %0b (value %0d)",
                                 want.is_final, got.is_final, want.sorted_value));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    hsort_if #(.T_PAYLOAD(t_in_item))  sort_in_if ();
    hsort_if #(.T_PAYLOAD(t_out_item)) sort_out_if ();

    heap_sorter #(
        .DEPTH (SET_DEPTH),
        .WIDTH (ITEM_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sort_in  (sort_in_if),
        .o_sort_out (sort_out_if)
    );

    sort_checker chk = new();
    int  items_sent;
    bit  in_steady;
    bit  out_steady;
    int  results_seen;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    // Sink side: random stalls, occasionally long runs with ready held high.
    initial begin
        int gap;
        sort_out_if.ready = 1'b0;
        results_seen      = 0;
        forever begin
            if (results_seen % 32 == 0) out_steady = ($urandom_range(0, 3) == 0);
            gap = out_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                sort_out_if.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            sort_out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(sort_out_if.valid && sort_out_if.ready));
            chk.check_sorted(sort_out_if.data);
            results_seen++;
        end
    end

    task automatic send_item(input t_elem value, input bit last);
        int gap;
        gap = in_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            @(negedge i_clk);
            sort_in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        sort_in_if.valid        <= 1'b1;
        sort_in_if.data.value   <= value;
        sort_in_if.data.is_last <= last;
        do @(posedge i_clk); while (!(sort_in_if.valid && sort_in_if.ready));
        chk.take_element(sort_in_if.data);
        items_sent++;
    endtask

    // Without the last flag a set closes only once the store is full.
    task automatic send_set(input t_elem_q vals, input bit flag_last);
        in_steady = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < vals.size(); k++)
            send_item(vals[k], flag_last && (k == vals.size() - 1));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        sort_in_if.valid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
    endtask

    function automatic t_elem draw_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_elem'($urandom);
            4, 5:       return t_elem'($signed($urandom_range(0, 16)) - 8);
            6: begin
                case ($urandom_range(0, 4))
                    0:       return VAL_MAX;
                    1:       return VAL_MIN;
                    2:       return t_elem'(0);
                    3:       return t_elem'(-1);
                    default: return t_elem'(1);
                endcase
            end
            7:       return VAL_MIN + t_elem'($urandom_range(0, 15));
            default: return VAL_MAX - t_elem'($urandom_range(0, 15));
        endcase
    endfunction

    initial begin
        t_elem_q vals;
        int      set_size;
        bit      flag_last;
        int      random_start;

        items_sent              = 0;
        in_steady               = 1'b0;
        i_rst_n                 = 1'b0;
        sort_in_if.valid        = 1'b0;
        sort_in_if.data.value   = '0;
        sort_in_if.data.is_last = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single element, reversed pair, extremes, ties, already ascending
        vals = '{VAL_MAX};
        send_set(vals, 1'b1);
        vals = '{VAL_MAX, VAL_MIN};
        send_set(vals, 1'b1);
        vals = '{t_elem'(0), t_elem'(-1), t_elem'(1), VAL_MIN, VAL_MAX,
                 VAL_MIN + 1, VAL_MAX - 1};
        send_set(vals, 1'b1);
        vals = '{t_elem'(5), t_elem'(-5), t_elem'(5), t_elem'(5), t_elem'(-5)};
        send_set(vals, 1'b1);
        vals = '{t_elem'(-3), t_elem'(-2), t_elem'(-1), t_elem'(0), t_elem'(1),
                 t_elem'(2), t_elem'(3)};
        send_set(vals, 1'b1);
        drain_results();

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            flag_last = 1'b1;
            case ($urandom_range(0, 19))
                14, 15, 16: set_size = $urandom_range(9, 24);
                17:         set_size = $urandom_range(25, SET_DEPTH - 1);
                18: begin
                    set_size  = SET_DEPTH;
                    flag_last = 1'b0;
                end
                19:         set_size = SET_DEPTH;
                default:    set_size = $urandom_range(1, 8);
            endcase
            vals.delete();
            for (int k = 0; k < set_size; k++) vals.push_back(draw_value());
            send_set(vals, flag_last);
            if ($urandom_range(0, 7) == 0) drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (chk.errors == 0 && chk.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
